@@ rtl/greedy_change_dispenser_defines.svh @@
// ----------------------------------------------------------------------------
// greedy_change_dispenser_defines: assertion macros
// Shared assertion forms clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef GREEDY_CHANGE_DISPENSER_DEFINES_SVH
`define GREEDY_CHANGE_DISPENSER_DEFINES_SVH

// General property check, disabled in reset
`define GCHG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication, disabled in reset
`define GCHG_ASSERT_NOW(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

`endif

@@ rtl/gchg_pkg.sv @@
// ----------------------------------------------------------------------------
// gchg_pkg
// Widths, register indexes and sequencer states of the change dispenser.
// ----------------------------------------------------------------------------
`default_nettype none

package gchg_pkg;

    localparam int MAX_NOTE_KINDS = 7;
    localparam int AMOUNT_W       = 32;
    localparam int VALUE_W        = 20;
    localparam int KIND_W         = 3;
    localparam int CFG_IDX_W      = 4;
    localparam int BIT_CNT_W      = 5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NOTE_KINDS   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOTE_VALUE_0 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOTE_VALUE_6 = 4'd7;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

@@ rtl/greedy_change_dispenser.sv @@
// ----------------------------------------------------------------------------
// greedy_change_dispenser
// Splits an amount over the configured note values, largest value first.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall | amount
//  out     | output    | out_valid/out_stall | face_value, note_count, leftover, last
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
//
//  Per note kind: a selection scan over every entry (one compare unit, one entry a cycle),
//  then a restoring division (one subtractor, one quotient bit a cycle),
//  skipped for a zero note value, then the result, held while the output stalls.
//  in_stall stays high from input transfer until the last result is taken.
//  Reset restores note_kinds = 1 and all note values = 1.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_change_dispenser (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // input channel
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [gchg_pkg::AMOUNT_W-1:0]      amount,
    // output channel
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic      [gchg_pkg::VALUE_W-1:0]       face_value,
    output logic      [gchg_pkg::AMOUNT_W-1:0]      note_count,
    output logic      [gchg_pkg::AMOUNT_W-1:0]      leftover,
    output logic                                    last,
    // configuration port
    input  wire logic                               cfg_we,
    input  wire logic [gchg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [gchg_pkg::VALUE_W-1:0]       cfg_data
);

    localparam int NK = gchg_pkg::MAX_NOTE_KINDS;
    localparam int AW = gchg_pkg::AMOUNT_W;
    localparam int VW = gchg_pkg::VALUE_W;
    localparam int KW = gchg_pkg::KIND_W;
    localparam int BW = gchg_pkg::BIT_CNT_W;

    gchg_pkg::state_t state_reg, state_next;

    logic [KW-1:0] kinds_reg;
    logic [VW-1:0] value_reg [NK];

    logic [NK-1:0] used_reg,       used_next;
    logic [KW-1:0] scan_idx_reg,   scan_idx_next;
    logic [KW-1:0] best_idx_reg,   best_idx_next;
    logic [VW-1:0] best_val_reg,   best_val_next;
    logic          best_ok_reg,    best_ok_next;
    logic [KW-1:0] kind_cnt_reg,   kind_cnt_next;
    logic [AW-1:0] rem_reg,        rem_next;
    logic [AW-1:0] quot_reg,       quot_next;
    logic [VW-1:0] part_reg,       part_next;
    logic [BW-1:0] bit_cnt_reg,    bit_cnt_next;

    logic [VW-1:0] face_reg,  face_next;
    logic [AW-1:0] count_reg, count_next;
    logic [AW-1:0] left_reg,  left_next;
    logic          last_reg,  last_next;

    logic [KW-1:0] k_use;
    logic [KW-1:0] cfg_slot;
    logic          cand;
    logic [KW-1:0] sel_idx;
    logic [VW-1:0] sel_val;
    logic [VW:0]   div_shift;
    logic [VW:0]   div_diff;
    logic          div_ge;
    logic          final_kind;

    // Kinds in use: zero counts as one
    assign k_use      = (kinds_reg == '0) ? KW'(1) : kinds_reg;
    assign final_kind = (kind_cnt_reg == k_use - KW'(1));
    assign cfg_slot   = KW'(cfg_index - gchg_pkg::REG_NOTE_VALUE_0);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kinds_reg <= KW'(1);
            for (int i = 0; i < NK; i++)
            begin
                value_reg[i] <= VW'(1);
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == gchg_pkg::REG_NOTE_KINDS)
            begin
                kinds_reg <= cfg_data[KW-1:0];
            end
            else if (cfg_index >= gchg_pkg::REG_NOTE_VALUE_0 &&
                     cfg_index <= gchg_pkg::REG_NOTE_VALUE_6)
            begin
                value_reg[cfg_slot] <= cfg_data;
            end
        end
    end

    // Selection scan: largest unused value, earliest index wins ties
    assign cand = !used_reg[scan_idx_reg] && (scan_idx_reg < k_use) &&
                  (!best_ok_reg || value_reg[scan_idx_reg] > best_val_reg);
    assign sel_idx = cand ? scan_idx_reg : best_idx_reg;
    assign sel_val = cand ? value_reg[scan_idx_reg] : best_val_reg;

    // Restoring division step
    assign div_shift = {part_reg, quot_reg[AW-1]};
    assign div_ge    = (div_shift >= {1'b0, best_val_reg});
    assign div_diff  = div_shift - {1'b0, best_val_reg};

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        used_next     = used_reg;
        scan_idx_next = scan_idx_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        best_ok_next  = best_ok_reg;
        kind_cnt_next = kind_cnt_reg;
        rem_next      = rem_reg;
        quot_next     = quot_reg;
        part_next     = part_reg;
        bit_cnt_next  = bit_cnt_reg;
        face_next     = face_reg;
        count_next    = count_reg;
        left_next     = left_reg;
        last_next     = last_reg;

        unique case (state_reg)
            gchg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    rem_next      = amount;
                    used_next     = '0;
                    kind_cnt_next = '0;
                    scan_idx_next = '0;
                    best_ok_next  = 1'b0;
                    state_next    = gchg_pkg::ST_SCAN;
                end
            end

            gchg_pkg::ST_SCAN:
            begin
                best_idx_next = sel_idx;
                best_val_next = sel_val;
                best_ok_next  = best_ok_reg || cand;
                scan_idx_next = scan_idx_reg + KW'(1);
                if (scan_idx_reg == KW'(NK - 1))
                begin
                    used_next[sel_idx] = 1'b1;
                    face_next          = sel_val;
                    last_next          = final_kind;
                    if (sel_val == '0)
                    begin
                        // zero note value: nothing dispensed, amount passes on
                        count_next = '0;
                        left_next  = rem_reg;
                        state_next = gchg_pkg::ST_EMIT;
                    end
                    else
                    begin
                        quot_next    = rem_reg;
                        part_next    = '0;
                        bit_cnt_next = '0;
                        state_next   = gchg_pkg::ST_DIV;
                    end
                end
            end

            gchg_pkg::ST_DIV:
            begin
                part_next    = div_ge ? div_diff[VW-1:0] : div_shift[VW-1:0];
                quot_next    = {quot_reg[AW-2:0], div_ge};
                bit_cnt_next = bit_cnt_reg + BW'(1);
                if (bit_cnt_reg == BW'(AW - 1))
                begin
                    count_next = quot_next;
                    left_next  = AW'(part_next);
                    rem_next   = AW'(part_next);
                    state_next = gchg_pkg::ST_EMIT;
                end
            end

            gchg_pkg::ST_EMIT:
            begin
                if (!out_stall)
                begin
                    if (last_reg)
                    begin
                        state_next = gchg_pkg::ST_IDLE;
                    end
                    else
                    begin
                        kind_cnt_next = kind_cnt_reg + KW'(1);
                        scan_idx_next = '0;
                        best_ok_next  = 1'b0;
                        state_next    = gchg_pkg::ST_SCAN;
                    end
                end
            end

            default:
            begin
                state_next = gchg_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= gchg_pkg::ST_IDLE;
            used_reg     <= '0;
            scan_idx_reg <= '0;
            best_ok_reg  <= 1'b0;
            kind_cnt_reg <= '0;
            bit_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            scan_idx_reg <= scan_idx_next;
            best_ok_reg  <= best_ok_next;
            kind_cnt_reg <= kind_cnt_next;
            bit_cnt_reg  <= bit_cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
        part_reg     <= part_next;
        face_reg     <= face_next;
        count_reg    <= count_next;
        left_reg     <= left_next;
        last_reg     <= last_next;
    end

    // Ports
    assign in_stall   = (state_reg != gchg_pkg::ST_IDLE);
    assign out_valid  = (state_reg == gchg_pkg::ST_EMIT);
    assign face_value = face_reg;
    assign note_count = count_reg;
    assign leftover   = left_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

@@ rtl/gchg_checker.sv @@
// ----------------------------------------------------------------------------
// gchg_checker
// Port-level checks on the change dispenser, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "greedy_change_dispenser_defines.svh"

module gchg_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               in_valid,
    input wire logic                               in_stall,
    input wire logic                               out_valid,
    input wire logic                               out_stall,
    input wire logic [gchg_pkg::VALUE_W-1:0]       face_value,
    input wire logic [gchg_pkg::AMOUNT_W-1:0]      note_count,
    input wire logic [gchg_pkg::AMOUNT_W-1:0]      leftover,
    input wire logic                               last
);

    logic in_xfer;
    logic out_xfer;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;

    // Accepted amount keeps the input side busy
    `GCHG_ASSERT(a_busy_after_in, in_xfer |=> in_stall, "input not stalled after transfer")

    // No new request while a result is pending
    `GCHG_ASSERT_NOW(a_out_blocks_in, out_valid, in_stall, "input open with result pending")

    // Next result always needs at least a scan, so no back-to-back results
    `GCHG_ASSERT(a_gap_after_out, out_xfer |=> !out_valid, "result follows without gap")

    // Held result stays put
    `GCHG_ASSERT(a_out_hold,
        out_valid && out_stall |=> out_valid && $stable(face_value) &&
        $stable(note_count) && $stable(leftover) && $stable(last),
        "stalled result changed")

endmodule

bind greedy_change_dispenser gchg_checker u_gchg_checker (.*);

`default_nettype wire
